// File: sv/ppmd_pkg.sv
// Shared types and constants for the PPM pulse train decoder.
package ppmd_pkg;

    localparam int TIME_W    = 32;
    localparam int DELTA_W   = 16;
    localparam int STATUS_W  = 3;
    localparam int CH_IDX_W  = 4;
    localparam int CPF_W     = 4;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 4;

    typedef enum logic [STATUS_W-1:0] {
        STAT_IGNORED = 3'd0,
        STAT_IDLE    = 3'd1,
        STAT_SYNC    = 3'd2,
        STAT_STORED  = 3'd3,
        STAT_CHANNEL = 3'd4,
        STAT_LOST    = 3'd5
    } ppmd_status_t;

    typedef enum logic [1:0] {
        REG_SYNC_MIN  = 2'd0,
        REG_PULSE_MIN = 2'd1,
        REG_PULSE_MAX = 2'd2,
        REG_CPF       = 2'd3
    } ppmd_reg_t;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic put;
    } ppmd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_put;
    } ppmd_stat_t;

endpackage

// File: sv/ppmd_ctrl.sv
// Controller state machine that sequences capture, evaluation and result beats.
module ppmd_ctrl
    import ppmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ppmd_stat_t stat,
    output ppmd_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EVAL = 3'b010,
        S_PUT  = 3'b100
    } ppmd_state_t;

    ppmd_state_t state_reg;
    ppmd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.evaluate = 1'b1;
                state_next   = S_PUT;
            end
            S_PUT: begin
                cmd.put = stat.out_free;
                if (stat.out_free && stat.last_put) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/ppmd_datapath.sv
// Datapath holding decoder state, channel staging and the output register.
module ppmd_datapath
    import ppmd_pkg::*;
#(
    parameter int MAX_CHANNELS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ppmd_cmd_t            cmd,
    output ppmd_stat_t           stat,
    input  logic [TIME_W-1:0]    s_edge_time_us,
    input  logic                 s_from_ppm_pin,
    input  logic [DELTA_W-1:0]   sync_min_us,
    input  logic [DELTA_W-1:0]   pulse_min_us,
    input  logic [DELTA_W-1:0]   pulse_max_us,
    input  logic [CPF_W-1:0]     channels_per_frame,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [CH_IDX_W-1:0]  m_channel_index,
    output logic [DELTA_W-1:0]   m_channel_value,
    output logic                 m_frame_last,
    output logic                 m_update_flag,
    output logic                 m_connected
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CMP_W = (CNT_W > CPF_W) ? CNT_W : CPF_W;

    logic [TIME_W-1:0]  in_time_reg;
    logic               in_pin_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic               locked_reg;
    logic [CNT_W-1:0]   pulse_count_reg;
    logic [DELTA_W-1:0] staging_reg [MAX_CHANNELS];
    logic               update_seen_reg;
    logic               link_seen_reg;
    ppmd_status_t       res_status_reg;
    logic               res_multi_reg;
    logic [CNT_W-1:0]   frame_n_reg;
    logic [IDX_W-1:0]   emit_cnt_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    ppmd_status_t       m_status_reg;
    logic [CH_IDX_W-1:0] m_channel_index_reg;
    logic [DELTA_W-1:0] m_channel_value_reg;
    logic               m_frame_last_reg;
    logic               m_update_flag_reg;
    logic               m_connected_reg;

    logic [DELTA_W-1:0] delta;
    logic               is_sync;
    logic               is_pulse;
    logic [CNT_W-1:0]   slot;
    logic [CNT_W-1:0]   new_count;
    logic [CMP_W-1:0]   frame_len;
    logic               frame_full;

    assign delta    = in_time_reg[DELTA_W-1:0] - prev_time_reg[DELTA_W-1:0];
    assign is_sync  = (delta >= sync_min_us);
    assign is_pulse = (delta >= pulse_min_us) && (delta <= pulse_max_us);

    always_comb begin
        if (pulse_count_reg >= CNT_W'(MAX_CHANNELS)) begin
            slot = CNT_W'(MAX_CHANNELS - 1);
        end else begin
            slot = pulse_count_reg;
        end
        new_count = slot + CNT_W'(1);
        if (channels_per_frame == '0) begin
            frame_len = CMP_W'(1);
        end else if (CMP_W'(channels_per_frame) > CMP_W'(MAX_CHANNELS)) begin
            frame_len = CMP_W'(MAX_CHANNELS);
        end else begin
            frame_len = CMP_W'(channels_per_frame);
        end
        frame_full = (CMP_W'(new_count) >= frame_len);
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.last_put = !res_multi_reg
                           || ((CNT_W'(emit_cnt_reg) + CNT_W'(1)) == frame_n_reg);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_time_reg <= s_edge_time_us;
            in_pin_reg  <= s_from_ppm_pin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg   <= '0;
            locked_reg      <= 1'b0;
            pulse_count_reg <= '0;
            update_seen_reg <= 1'b0;
            link_seen_reg   <= 1'b0;
            res_status_reg  <= STAT_IGNORED;
            res_multi_reg   <= 1'b0;
            frame_n_reg     <= '0;
            emit_cnt_reg    <= '0;
        end else if (cmd.evaluate) begin
            emit_cnt_reg  <= '0;
            res_multi_reg <= 1'b0;
            if (!in_pin_reg) begin
                res_status_reg <= STAT_IGNORED;
            end else begin
                link_seen_reg <= 1'b1;
                prev_time_reg <= in_time_reg;
                if (!locked_reg) begin
                    if (is_sync) begin
                        locked_reg      <= 1'b1;
                        pulse_count_reg <= '0;
                        update_seen_reg <= 1'b0;
                        res_status_reg  <= STAT_SYNC;
                    end else begin
                        res_status_reg <= STAT_IDLE;
                    end
                end else if (is_sync) begin
                    pulse_count_reg <= '0;
                    update_seen_reg <= 1'b1;
                    res_status_reg  <= STAT_SYNC;
                end else if (is_pulse) begin
                    if (frame_full) begin
                        pulse_count_reg <= '0;
                        res_multi_reg   <= 1'b1;
                        frame_n_reg     <= new_count;
                        res_status_reg  <= STAT_CHANNEL;
                    end else begin
                        pulse_count_reg <= new_count;
                        res_status_reg  <= STAT_STORED;
                    end
                end else begin
                    locked_reg     <= 1'b0;
                    res_status_reg <= STAT_LOST;
                end
            end
        end else if (cmd.put) begin
            emit_cnt_reg <= emit_cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.evaluate && in_pin_reg && locked_reg && !is_sync && is_pulse) begin
            staging_reg[slot[IDX_W-1:0]] <= delta;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.put) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put) begin
            m_status_reg      <= res_status_reg;
            m_update_flag_reg <= update_seen_reg;
            m_connected_reg   <= link_seen_reg;
            m_frame_last_reg  <= stat.last_put;
            if (res_multi_reg) begin
                m_channel_index_reg <= CH_IDX_W'(emit_cnt_reg);
                m_channel_value_reg <= staging_reg[emit_cnt_reg];
            end else begin
                m_channel_index_reg <= '0;
                m_channel_value_reg <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_channel_index = m_channel_index_reg;
    assign m_channel_value = m_channel_value_reg;
    assign m_frame_last    = m_frame_last_reg;
    assign m_update_flag   = m_update_flag_reg;
    assign m_connected     = m_connected_reg;

    a_put_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.put |-> stat.out_free)
        else $error("Result beat loaded while the output register was still full.");

    a_single_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != STAT_CHANNEL)) |-> m_frame_last_reg)
        else $error("A non-channel result beat was not marked as last.");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_channel_index_reg < CH_IDX_W'(MAX_CHANNELS)))
        else $error("Channel index beyond the staging depth.");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pulse_count_reg <= CNT_W'(MAX_CHANNELS))
        else $error("Pulse count beyond the staging depth.");

endmodule

// File: sv/ppm_pulse_train_decoder_unit.sv
// Top level of the PPM pulse train decoder with its APB register file.
//
//   Channel   Direction  Handshake         Payload
//   s_        in         s_valid/s_ready   edge_time_us, from_ppm_pin
//   m_        out        m_valid/m_ready   status, channel_index, channel_value,
//                                          frame_last, update_flag, connected
//   APB       in         psel/penable      sync_min_us, pulse_min_us,
//                                          pulse_max_us, channels_per_frame
//
// An edge is captured in S_IDLE and evaluated in S_EVAL, then S_PUT loads its result
// beats into the output register. The controller's beat sequencer accepts a new beat
// only once all results of the previous one are loaded into the output register.
// Reset is synchronous and active low. Control, decoder and APB registers get their
// defaults; the captured edge, channel staging and output payload are not reset.
// A low m_ready holds the sequencer while the output register is full.
module ppm_pulse_train_decoder_unit
    import ppmd_pkg::*;
#(
    parameter int MAX_CHANNELS = 10
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TIME_W-1:0]    s_edge_time_us,
    input  logic                 s_from_ppm_pin,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [CH_IDX_W-1:0]  m_channel_index,
    output logic [DELTA_W-1:0]   m_channel_value,
    output logic                 m_frame_last,
    output logic                 m_update_flag,
    output logic                 m_connected,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic [DELTA_W-1:0] sync_min_reg;
    logic [DELTA_W-1:0] pulse_min_reg;
    logic [DELTA_W-1:0] pulse_max_reg;
    logic [CPF_W-1:0]   cpf_reg;
    logic               cfg_write;
    ppmd_reg_t          reg_sel;
    ppmd_cmd_t          cmd;
    ppmd_stat_t         stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_sel   = ppmd_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_min_reg  <= DELTA_W'(2200);
            pulse_min_reg <= DELTA_W'(950);
            pulse_max_reg <= DELTA_W'(2050);
            cpf_reg       <= CPF_W'(8);
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_SYNC_MIN:  sync_min_reg  <= pwdata[DELTA_W-1:0];
                REG_PULSE_MIN: pulse_min_reg <= pwdata[DELTA_W-1:0];
                REG_PULSE_MAX: pulse_max_reg <= pwdata[DELTA_W-1:0];
                REG_CPF:       cpf_reg       <= pwdata[CPF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_SYNC_MIN:  prdata = APB_DW'(sync_min_reg);
            REG_PULSE_MIN: prdata = APB_DW'(pulse_min_reg);
            REG_PULSE_MAX: prdata = APB_DW'(pulse_max_reg);
            REG_CPF:       prdata = APB_DW'(cpf_reg);
            default:       prdata = '0;
        endcase
    end

    ppmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ppmd_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_edge_time_us     (s_edge_time_us),
        .s_from_ppm_pin     (s_from_ppm_pin),
        .sync_min_us        (sync_min_reg),
        .pulse_min_us       (pulse_min_reg),
        .pulse_max_us       (pulse_max_reg),
        .channels_per_frame (cpf_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_channel_index    (m_channel_index),
        .m_channel_value    (m_channel_value),
        .m_frame_last       (m_frame_last),
        .m_update_flag      (m_update_flag),
        .m_connected        (m_connected)
    );

endmodule
